@@ design/hrf_pkg.sv @@
`timescale 1ns / 1ps
package hrf_pkg;

  localparam int LENGTH_BITS_DEFAULT       = 24;
  localparam int HEADER_COUNT_BITS_DEFAULT = 16;
  localparam int NAME_LEN                  = 16;

  localparam logic [15:0] TIMEOUT_RESET = 16'd30;

  typedef logic [7:0] byte_t;
  typedef byte_t [0:NAME_LEN-1] name_t;

  localparam name_t LOWER_NAME = "Content-length: ";
  localparam name_t UPPER_NAME = "Content-Length: ";

  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_ZERO  = "0";
  localparam byte_t CH_NINE  = "9";
  localparam byte_t CH_G     = "G";
  localparam byte_t CH_E     = "E";
  localparam byte_t CH_T     = "T";
  localparam byte_t CH_P     = "P";
  localparam byte_t CH_O     = "O";
  localparam byte_t CH_S     = "S";
  localparam byte_t CH_SPACE = " ";

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    PH_METHOD    = 3'd0,
    PH_HEADER    = 3'd1,
    PH_BODY      = 3'd2,
    PH_DONE      = 3'd3,
    PH_BADMETHOD = 3'd4,
    PH_BADLEN    = 3'd5,
    PH_TIMEOUT   = 3'd6,
    PH_OVERFLOW  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_GET     = 2'd1,
    KIND_POST    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CAP_NONE   = 3'd0,
    CAP_EMPTY  = 3'd1,
    CAP_DIGITS = 3'd2,
    CAP_CR     = 3'd3,
    CAP_VALID  = 3'd4,
    CAP_BAD    = 3'd5
  } cap_t;

  typedef enum logic [2:0] {
    ST_WAITING   = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_BADMETHOD = 3'd2,
    ST_BADLEN    = 3'd3,
    ST_TIMEOUT   = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  typedef struct packed {
    status_t     status;
    logic        is_post;
    logic [15:0] header_bytes;
    logic [23:0] body_length;
  } result_t;

  function automatic logic [2:0] method_len(input kind_t kind);
    return (kind == KIND_POST) ? 3'd5 : 3'd4;
  endfunction

  function automatic byte_t method_char(input kind_t kind, input logic [2:0] pos);
    byte_t c;
    c = 8'h00;
    if (kind == KIND_POST) begin
      unique case (pos)
        3'd0: c = CH_P;
        3'd1: c = CH_O;
        3'd2: c = CH_S;
        3'd3: c = CH_T;
        3'd4: c = CH_SPACE;
        default: c = 8'h00;
      endcase
    end else begin
      unique case (pos)
        3'd0: c = CH_G;
        3'd1: c = CH_E;
        3'd2: c = CH_T;
        3'd3: c = CH_SPACE;
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

  function automatic byte_t end_char(input logic [1:0] pos);
    return pos[0] ? CH_LF : CH_CR;
  endfunction

  function automatic status_t phase_status(input phase_t ph);
    status_t s;
    unique case (ph)
      PH_DONE:      s = ST_COMPLETE;
      PH_BADMETHOD: s = ST_BADMETHOD;
      PH_BADLEN:    s = ST_BADLEN;
      PH_TIMEOUT:   s = ST_TIMEOUT;
      PH_OVERFLOW:  s = ST_OVERFLOW;
      default:      s = ST_WAITING;
    endcase
    return s;
  endfunction

endpackage

@@ design/hrf_in_if.sv @@
`timescale 1ns / 1ps
interface hrf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

@@ design/hrf_out_if.sv @@
`timescale 1ns / 1ps
interface hrf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        is_post;
  logic [15:0] header_bytes;
  logic [23:0] body_length;

  modport source (output valid, output status, output is_post, output header_bytes,
                  output body_length, input ready);
  modport sink (input valid, input status, input is_post, input header_bytes,
                input body_length, output ready);
endinterface

@@ design/http_request_framer.sv @@
`timescale 1ns / 1ps
// All parsing is a single pass from state to result, which is then registered.
// Throughput: one transaction per cycle, except while the skid entry holds a result.
// A two-entry output register keeps input accepted while one result waits downstream.
// Reset (rst, synchronous): request state cleared, timeout_seconds back to 30, no results held.
module http_request_framer #(
  parameter int LENGTH_BITS       = hrf_pkg::LENGTH_BITS_DEFAULT,
  parameter int HEADER_COUNT_BITS = hrf_pkg::HEADER_COUNT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        timeout_we,
  input  logic [15:0] timeout_data,
  hrf_in_if.sink      req_in,
  hrf_out_if.source   res_out
);
  import hrf_pkg::*;

  localparam int LB  = LENGTH_BITS;
  localparam int HCB = HEADER_COUNT_BITS;
  localparam logic [HCB-1:0] HMAX = {HCB{1'b1}};

  logic [15:0]    timeout_seconds;
  phase_t         phase, phase_next;
  logic [2:0]     method_pos, method_pos_next;
  kind_t          kind, kind_next;
  logic [1:0]     end_pos, end_pos_next;
  logic [HCB-1:0] header_count, header_count_next;
  logic [LB-1:0]  body_count, body_count_next;
  logic [LB-1:0]  chosen, chosen_next;
  logic [15:0]    idle, idle_next;

  logic           accept;
  opcode_t        op;
  byte_t          b;
  logic           cap_step;
  logic           cap_clear;
  cap_t           lower_st, upper_st;
  logic [LB:0]    lower_val, upper_val;

  result_t        r;
  logic           main_valid, skid_valid, pop;
  result_t        main_res, skid_res;
  logic [HCB+15:0] hc_wide;
  logic [LB+23:0]  len_wide;

  assign accept    = req_in.valid && req_in.ready;
  assign op        = opcode_t'(req_in.opcode);
  assign b         = req_in.data_byte;
  assign cap_step  = accept && (op == OP_BYTE) && (phase == PH_HEADER);
  assign cap_clear = accept && (op == OP_CLEAR);

  hrf_len_capture #(.LENGTH_BITS(LB)) u_lower (
    .clk         (clk),
    .rst         (rst),
    .clear       (cap_clear),
    .step        (cap_step),
    .data_byte   (b),
    .name        (LOWER_NAME),
    .status_next (lower_st),
    .value_next  (lower_val)
  );

  hrf_len_capture #(.LENGTH_BITS(LB)) u_upper (
    .clk         (clk),
    .rst         (rst),
    .clear       (cap_clear),
    .step        (cap_step),
    .data_byte   (b),
    .name        (UPPER_NAME),
    .status_next (upper_st),
    .value_next  (upper_val)
  );

  always_comb begin
    logic [2:0]  end_step;
    cap_t        sel_st;
    logic [LB:0] sel_val;
    end_step          = 3'd0;
    sel_st            = CAP_NONE;
    sel_val           = '0;
    phase_next        = phase;
    method_pos_next   = method_pos;
    kind_next         = kind;
    end_pos_next      = end_pos;
    header_count_next = header_count;
    body_count_next   = body_count;
    chosen_next       = chosen;
    idle_next         = idle;
    if (accept) begin
      unique case (op)
        OP_BYTE: begin
          if ((phase == PH_METHOD) || (phase == PH_HEADER)) begin
            idle_next = '0;
            if (header_count != HMAX) begin
              header_count_next = header_count + 1'b1;
            end
          end
          unique case (phase)
            PH_METHOD: begin
              if (method_pos == 3'd0) begin
                if (b == CH_G) begin
                  kind_next       = KIND_GET;
                  method_pos_next = 3'd1;
                end else if (b == CH_P) begin
                  kind_next       = KIND_POST;
                  method_pos_next = 3'd1;
                end else begin
                  phase_next = PH_BADMETHOD;
                end
              end else if ((method_pos < method_len(kind)) &&
                           (b == method_char(kind, method_pos))) begin
                method_pos_next = method_pos + 3'd1;
                if (method_pos_next >= method_len(kind)) begin
                  phase_next = PH_HEADER;
                end
              end else begin
                phase_next = PH_BADMETHOD;
              end
            end
            PH_HEADER: begin
              if (b == end_char(end_pos)) begin
                end_step = {1'b0, end_pos} + 3'd1;
              end else begin
                end_step = (b == CH_CR) ? 3'd1 : 3'd0;
              end
              if (end_step == 3'd4) begin
                end_pos_next = 2'd0;
                if (kind != KIND_POST) begin
                  phase_next = PH_DONE;
                end else begin
                  if (lower_st != CAP_NONE) begin
                    sel_st  = lower_st;
                    sel_val = lower_val;
                  end else begin
                    sel_st  = upper_st;
                    sel_val = upper_val;
                  end
                  if (sel_st != CAP_VALID) begin
                    phase_next = PH_BADLEN;
                  end else if (sel_val[LB]) begin
                    phase_next = PH_OVERFLOW;
                  end else begin
                    chosen_next = sel_val[LB-1:0];
                    phase_next  = (sel_val[LB-1:0] == '0) ? PH_DONE : PH_BODY;
                  end
                end
              end else begin
                end_pos_next = end_step[1:0];
              end
            end
            PH_BODY: begin
              idle_next       = '0;
              body_count_next = body_count + 1'b1;
              if (body_count_next >= chosen) begin
                phase_next = PH_DONE;
              end
            end
            default: begin
            end
          endcase
        end
        OP_CLEAR: begin
          phase_next        = PH_METHOD;
          method_pos_next   = '0;
          kind_next         = KIND_UNKNOWN;
          end_pos_next      = '0;
          header_count_next = '0;
          body_count_next   = '0;
          chosen_next       = '0;
          idle_next         = '0;
        end
        OP_TICK: begin
          if ((phase == PH_METHOD) || (phase == PH_HEADER) || (phase == PH_BODY)) begin
            if (idle != 16'hFFFF) begin
              idle_next = idle + 16'd1;
            end
            if (idle_next > timeout_seconds) begin
              phase_next = PH_TIMEOUT;
            end
          end
        end
        OP_NOP: begin
        end
      endcase
    end
  end

  always_comb begin
    hc_wide        = {16'b0, header_count_next};
    len_wide       = {24'b0, chosen_next};
    r.status       = phase_status(phase_next);
    r.is_post      = (kind_next == KIND_POST) && (phase_next != PH_METHOD) &&
                     (phase_next != PH_BADMETHOD);
    r.header_bytes = hc_wide[15:0];
    r.body_length  = len_wide[23:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_seconds <= TIMEOUT_RESET;
    end else if (timeout_we) begin
      timeout_seconds <= timeout_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_METHOD;
      method_pos   <= '0;
      kind         <= KIND_UNKNOWN;
      end_pos      <= '0;
      header_count <= '0;
      body_count   <= '0;
      chosen       <= '0;
      idle         <= '0;
    end else begin
      phase        <= phase_next;
      method_pos   <= method_pos_next;
      kind         <= kind_next;
      end_pos      <= end_pos_next;
      header_count <= header_count_next;
      body_count   <= body_count_next;
      chosen       <= chosen_next;
      idle         <= idle_next;
    end
  end

  // hold a second result while the first one stalls
  assign req_in.ready = !skid_valid;
  assign pop          = main_valid && res_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        main_res   <= skid_res;
        skid_valid <= accept;
        skid_res   <= r;
      end else begin
        main_valid <= accept;
        main_res   <= r;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
      skid_res   <= r;
    end
  end

  assign res_out.valid        = main_valid;
  assign res_out.status       = main_res.status;
  assign res_out.is_post      = main_res.is_post;
  assign res_out.header_bytes = main_res.header_bytes;
  assign res_out.body_length  = main_res.body_length;

endmodule

@@ design/hrf_len_capture.sv @@
`timescale 1ns / 1ps
module hrf_len_capture #(
  parameter int LENGTH_BITS = hrf_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  hrf_pkg::name_t     name,
  output hrf_pkg::cap_t      status_next,
  output logic [LENGTH_BITS:0] value_next
);
  import hrf_pkg::*;

  localparam int VW = LENGTH_BITS + 1;
  localparam int PW = LENGTH_BITS + 4;
  localparam logic [PW-1:0] LIMIT = {4'b0000, {LENGTH_BITS{1'b1}}};
  localparam logic [VW-1:0] SAT   = {1'b1, {LENGTH_BITS{1'b0}}};

  cap_t          status;
  logic [4:0]    npos;
  logic [4:0]    npos_next;
  logic [VW-1:0] value;
  logic          digit;
  logic [PW-1:0] ext;
  logic [PW-1:0] prod;
  logic [7:0]    dval;

  assign digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign dval  = data_byte - CH_ZERO;
  assign ext   = PW'(value);
  assign prod  = (ext << 3) + (ext << 1) + PW'(dval[3:0]);

  always_comb begin
    status_next = status;
    value_next  = value;
    npos_next   = npos;
    if (step) begin
      unique case (status)
        CAP_NONE: begin
          if ((npos < 5'(NAME_LEN)) && (data_byte == name[npos[3:0]])) begin
            npos_next = npos + 5'd1;
          end else begin
            npos_next = (data_byte == name[0]) ? 5'd1 : 5'd0;
          end
          if (npos_next >= 5'(NAME_LEN)) begin
            status_next = CAP_EMPTY;
            value_next  = '0;
          end
        end
        CAP_EMPTY, CAP_DIGITS: begin
          if (digit) begin
            value_next  = (prod > LIMIT) ? SAT : prod[VW-1:0];
            status_next = CAP_DIGITS;
          end else if ((data_byte == CH_CR) && (status == CAP_DIGITS)) begin
            status_next = CAP_CR;
          end else begin
            status_next = CAP_BAD;
          end
        end
        CAP_CR: begin
          status_next = (data_byte == CH_LF) ? CAP_VALID : CAP_BAD;
        end
        CAP_VALID, CAP_BAD: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      status <= CAP_NONE;
      npos   <= '0;
      value  <= '0;
    end else begin
      status <= status_next;
      npos   <= npos_next;
      value  <= value_next;
    end
  end

endmodule
